FILE: src/ycbcr422_upsample_to_rgb_assert.svh
// Assertion macros for the 4:2:2 to RGB converter.
// Each expects clk and rst_n in the scope of use.
`ifndef YCBCR422_UPSAMPLE_TO_RGB_ASSERT_SVH
`define YCBCR422_UPSAMPLE_TO_RGB_ASSERT_SVH

// Consequence holds in the same cycle as the condition
`define YCU_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ycbcr422_upsample_to_rgb: same-cycle check failed");

// Consequence holds in the cycle after the condition
`define YCU_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ycbcr422_upsample_to_rgb: next-cycle check failed");

`endif

FILE: src/ycu_pkg.sv
package ycu_pkg;

  localparam int COEF_W  = 10;
  localparam int IDX_W   = 2;
  localparam int DELTA_W = 11;              // chroma offset in quarter units, signed
  localparam int PROD_W  = COEF_W + 1 + DELTA_W;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_CR_TO_RED   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CR_TO_GREEN = 2'd1;
  localparam logic [IDX_W-1:0] REG_CB_TO_GREEN = 2'd2;
  localparam logic [IDX_W-1:0] REG_CB_TO_BLUE  = 2'd3;

  // Chroma midpoint, quarter units
  localparam logic signed [DELTA_W-1:0] CHROMA_MID = 11'sd512;

  typedef struct packed {
    logic [7:0] luma_even;
    logic [7:0] luma_odd;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       row_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_last_pixel;
    logic       run_last;
  } out_item_t;

  // One pixel on its way through the datapath
  typedef struct packed {
    logic [7:0]         luma;
    logic [DELTA_W-1:0] dcb;
    logic [DELTA_W-1:0] dcr;
    logic               row_last;
    logic               run_last;
  } pix_task_t;

  typedef struct packed {
    logic [7:0]        luma;
    logic [PROD_W-1:0] p_red;
    logic [PROD_W-1:0] p_green_cr;
    logic [PROD_W-1:0] p_green_cb;
    logic [PROD_W-1:0] p_blue;
    logic              row_last;
    logic              run_last;
  } pix_prod_t;

  // 3*heavy + light: interpolated chroma in quarter units
  function automatic logic [9:0] quarter_mix(logic [7:0] heavy, logic [7:0] light);
    logic [9:0] h;
    h = {2'b00, heavy};
    return (h << 1) + h + {2'b00, light};
  endfunction

endpackage

FILE: src/ycu_stream_if.sv
interface ycu_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/ycbcr422_upsample_to_rgb.sv
// 4:2:2 to RGB converter with horizontal chroma interpolation. Each input transfer carries one
// pair (two luma samples, shared Cb and Cr); the block holds a pair back until the next pair's
// chroma is known, then issues the held pair's two pixels, even pixel first. A pair flagged
// row_end is flushed straight away after any held pair, with its own chroma replicated, so it
// causes up to four pixels; a first pair of a row that is not flagged row_end causes none. Pixels
// leave at one per cycle while the output is not stalled: the item register issues one pixel
// each cycle that the next stage can take, and accepts the next pair once the current one is done.
// After issue a pixel passes the task, product and result registers to the output. run_last
// marks the last pixel caused by a transfer. Coefficients are unsigned Q(COEF_FRAC_BITS) and
// should be written only while the block is idle.
`include "ycbcr422_upsample_to_rgb_assert.svh"

module ycbcr422_upsample_to_rgb
  import ycu_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  ycu_stream_if.sink          in_chan,
  ycu_stream_if.source        out_chan,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]   cfg_wdata
);

  localparam int SHIFT = COEF_FRAC_BITS + 2;
  localparam int BASE_W = SHIFT + 8;
  localparam int ACC_W = ((BASE_W > 20) ? BASE_W : 20) + 2;
  localparam int COEF_MAX = (1 << COEF_W) - 1;

  // Reset coefficients, rounded from the standard weights
  localparam int RST_CR_R_I = (1371 * (2 ** COEF_FRAC_BITS) + 500) / 1000;
  localparam int RST_CR_G_I = (698 * (2 ** COEF_FRAC_BITS) + 500) / 1000;
  localparam int RST_CB_G_I = (336 * (2 ** COEF_FRAC_BITS) + 500) / 1000;
  localparam int RST_CB_B_I = (1732 * (2 ** COEF_FRAC_BITS) + 500) / 1000;
  localparam logic [COEF_W-1:0] RST_CR_R =
      (RST_CR_R_I > COEF_MAX) ? COEF_W'(COEF_MAX) : COEF_W'(RST_CR_R_I);
  localparam logic [COEF_W-1:0] RST_CR_G =
      (RST_CR_G_I > COEF_MAX) ? COEF_W'(COEF_MAX) : COEF_W'(RST_CR_G_I);
  localparam logic [COEF_W-1:0] RST_CB_G =
      (RST_CB_G_I > COEF_MAX) ? COEF_W'(COEF_MAX) : COEF_W'(RST_CB_G_I);
  localparam logic [COEF_W-1:0] RST_CB_B =
      (RST_CB_B_I > COEF_MAX) ? COEF_W'(COEF_MAX) : COEF_W'(RST_CB_B_I);

  // Floor by 2^-SHIFT and clamp to 0..255
  function automatic logic [7:0] sat8(logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[ACC_W-1]) begin
      res = 8'd0;
    end else if (|acc[ACC_W-2:BASE_W]) begin
      res = 8'hFF;
    end else begin
      res = acc[BASE_W-1:SHIFT];
    end
    return res;
  endfunction

  // Coefficient registers
  logic [COEF_W-1:0] coef_cr_red_r, coef_cr_green_r, coef_cb_green_r, coef_cb_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_cr_red_r   <= RST_CR_R;
      coef_cr_green_r <= RST_CR_G;
      coef_cb_green_r <= RST_CB_G;
      coef_cb_blue_r  <= RST_CB_B;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CR_TO_RED:   coef_cr_red_r   <= cfg_wdata;
        REG_CR_TO_GREEN: coef_cr_green_r <= cfg_wdata;
        REG_CB_TO_GREEN: coef_cb_green_r <= cfg_wdata;
        REG_CB_TO_BLUE:  coef_cb_blue_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Item register, held pair and pixel sequencing
  in_item_t  item_r;
  logic      item_v_r;
  logic [1:0] ph_r;
  logic      held_v_r;
  logic [7:0] held_ye_r, held_yo_r, held_cb_r, held_cr_r;

  logic      v1_r, v2_r, out_v_r;
  pix_task_t task_r;
  pix_prod_t prod_r;
  out_item_t out_r;

  logic out_adv, s2_free, s1_free;
  logic no_work, issue, item_done, in_xfer;
  logic [1:0] last_ph, idx;
  logic [7:0] own_cb, own_cr, sel_luma;
  logic [9:0] q_cb, q_cr;
  pix_task_t task_nxt;

  assign out_adv = !out_v_r || out_chan.ready;
  assign s2_free = !v2_r || out_adv;
  assign s1_free = !v1_r || s2_free;

  assign no_work   = !held_v_r && !item_r.row_end;
  assign last_ph   = {held_v_r & item_r.row_end, 1'b1};
  assign issue     = item_v_r && !no_work && s1_free;
  assign item_done = item_v_r && (no_work || (s1_free && ph_r == last_ph));
  assign in_chan.ready = !item_v_r || item_done;
  assign in_xfer   = in_chan.valid && in_chan.ready;

  // Pixel slot: 0/1 held pair, 2/3 current pair toward itself
  assign idx = ph_r + {!held_v_r, 1'b0};

  always_comb begin
    own_cb = idx[1] ? item_r.chroma_blue : held_cb_r;
    own_cr = idx[1] ? item_r.chroma_red : held_cr_r;
    if (idx[1]) begin
      sel_luma = idx[0] ? item_r.luma_odd : item_r.luma_even;
    end else begin
      sel_luma = idx[0] ? held_yo_r : held_ye_r;
    end
    q_cb = idx[0] ? quarter_mix(item_r.chroma_blue, own_cb)
                  : quarter_mix(own_cb, item_r.chroma_blue);
    q_cr = idx[0] ? quarter_mix(item_r.chroma_red, own_cr)
                  : quarter_mix(own_cr, item_r.chroma_red);
    task_nxt.luma     = sel_luma;
    task_nxt.dcb      = $signed({1'b0, q_cb}) - CHROMA_MID;
    task_nxt.dcr      = $signed({1'b0, q_cr}) - CHROMA_MID;
    task_nxt.row_last = (idx == 2'd3);
    task_nxt.run_last = (ph_r == last_ph);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      ph_r     <= 2'd0;
      held_v_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        item_v_r <= 1'b1;
        ph_r     <= 2'd0;
      end else if (item_done) begin
        item_v_r <= 1'b0;
      end else if (issue) begin
        ph_r <= ph_r + 2'd1;
      end
      if (item_done) begin
        held_v_r <= !item_r.row_end;
      end
      if (s1_free) begin
        v1_r <= issue;
      end
      if (s2_free) begin
        v2_r <= v1_r;
      end
      if (out_adv) begin
        out_v_r <= v2_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_chan.payload;
    end
    if (item_done && !item_r.row_end) begin
      held_ye_r <= item_r.luma_even;
      held_yo_r <= item_r.luma_odd;
      held_cb_r <= item_r.chroma_blue;
      held_cr_r <= item_r.chroma_red;
    end
    if (s1_free) begin
      task_r <= task_nxt;
    end
  end

  // Product stage: one multiplier per term
  pix_prod_t prod_nxt;

  always_comb begin
    prod_nxt.luma       = task_r.luma;
    prod_nxt.p_red      = $signed({1'b0, coef_cr_red_r}) * $signed(task_r.dcr);
    prod_nxt.p_green_cr = $signed({1'b0, coef_cr_green_r}) * $signed(task_r.dcr);
    prod_nxt.p_green_cb = $signed({1'b0, coef_cb_green_r}) * $signed(task_r.dcb);
    prod_nxt.p_blue     = $signed({1'b0, coef_cb_blue_r}) * $signed(task_r.dcb);
    prod_nxt.row_last   = task_r.row_last;
    prod_nxt.run_last   = task_r.run_last;
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      prod_r <= prod_nxt;
    end
  end

  // Sum, floor and clamp into the output register
  logic signed [ACC_W-1:0] base, acc_r_c, acc_g_c, acc_b_c;
  out_item_t out_nxt;

  always_comb begin
    base    = ACC_W'({prod_r.luma, {SHIFT{1'b0}}});
    acc_r_c = base + ACC_W'($signed(prod_r.p_red));
    acc_g_c = base - ACC_W'($signed(prod_r.p_green_cr)) - ACC_W'($signed(prod_r.p_green_cb));
    acc_b_c = base + ACC_W'($signed(prod_r.p_blue));
    out_nxt.red            = sat8(acc_r_c);
    out_nxt.green          = sat8(acc_g_c);
    out_nxt.blue           = sat8(acc_b_c);
    out_nxt.row_last_pixel = prod_r.row_last;
    out_nxt.run_last       = prod_r.run_last;
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid   = out_v_r;
  assign out_chan.payload = out_r;

  // Checks
  `YCU_ASSERT_SAME(a_row_last_ends_run, out_v_r && out_r.row_last_pixel, out_r.run_last)
  `YCU_ASSERT_NEXT(a_row_end_clears_held, item_done && item_r.row_end, !held_v_r)
  `YCU_ASSERT_SAME(a_idle_pair_one_cycle, item_v_r && !held_v_r && !item_r.row_end, item_done)

endmodule

FILE: tb/ycbcr422_upsample_to_rgb_tb.sv
module ycbcr422_upsample_to_rgb_tb;
  import ycu_pkg::*;

  localparam int COEF_FRAC        = 8;
  localparam int ACC_SHIFT        = COEF_FRAC + 2;
  localparam int LONG_HOLD_CYCLES = 80;
  // item register issue phases plus three pipeline registers, with margin
  localparam int SETTLE_CYCLES    = 12;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  ycu_stream_if #(.T(in_item_t))  in_if ();
  ycu_stream_if #(.T(out_item_t)) out_if ();

  ycbcr422_upsample_to_rgb #(.COEF_FRAC_BITS(COEF_FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predictor state: coefficients and the pair held back for interpolation
  logic [COEF_W-1:0] coef [4];
  logic              held_valid;
  logic [7:0]        held_luma_even, held_luma_odd, held_cb, held_cr;

  out_item_t pixel_q [$];
  int        n_fail = 0;
  bit        tx_idle_on;
  bit        rx_idle_on;
  bit        long_hold_req;

  // 3*heavy + light, quarter units
  function automatic logic [9:0] mix_quarter(logic [7:0] heavy, logic [7:0] light);
    return 10'(heavy) * 10'd3 + 10'(light);
  endfunction

  // floor by 2^-(frac+2), saturate to 0..255
  function automatic logic [7:0] clamp_component(longint acc);
    longint scaled;
    if (acc < 0) return 8'd0;
    scaled = acc >>> ACC_SHIFT;
    return (scaled > 255) ? 8'd255 : 8'(scaled);
  endfunction

  function automatic out_item_t rgb_pixel(logic [7:0] luma, logic [9:0] cb_q,
                                          logic [9:0] cr_q, logic ends_row);
    longint    base, dcb, dcr;
    out_item_t px;
    base  = longint'(luma) <<< ACC_SHIFT;
    dcb   = longint'(cb_q) - 512;
    dcr   = longint'(cr_q) - 512;
    px.red   = clamp_component(base + longint'(coef[REG_CR_TO_RED]) * dcr);
    px.green = clamp_component(base - longint'(coef[REG_CR_TO_GREEN]) * dcr
                                    - longint'(coef[REG_CB_TO_GREEN]) * dcb);
    px.blue  = clamp_component(base + longint'(coef[REG_CB_TO_BLUE]) * dcb);
    px.row_last_pixel = ends_row;
    px.run_last       = 1'b0;
    return px;
  endfunction

  // Expected pixels for one accepted pair; updates the held pair
  function automatic void predict_pair(in_item_t pair);
    out_item_t px [4];
    int        n;
    n = 0;
    if (held_valid) begin
      px[0] = rgb_pixel(held_luma_even, mix_quarter(held_cb, pair.chroma_blue),
                        mix_quarter(held_cr, pair.chroma_red), 1'b0);
      px[1] = rgb_pixel(held_luma_odd, mix_quarter(pair.chroma_blue, held_cb),
                        mix_quarter(pair.chroma_red, held_cr), 1'b0);
      n = 2;
    end
    if (pair.row_end) begin
      // row end: own chroma replicated as the next sample
      px[n]   = rgb_pixel(pair.luma_even, mix_quarter(pair.chroma_blue, pair.chroma_blue),
                          mix_quarter(pair.chroma_red, pair.chroma_red), 1'b0);
      px[n+1] = rgb_pixel(pair.luma_odd, mix_quarter(pair.chroma_blue, pair.chroma_blue),
                          mix_quarter(pair.chroma_red, pair.chroma_red), 1'b1);
      n += 2;
      held_valid = 1'b0;
    end else begin
      held_valid     = 1'b1;
      held_luma_even = pair.luma_even;
      held_luma_odd  = pair.luma_odd;
      held_cb        = pair.chroma_blue;
      held_cr        = pair.chroma_red;
    end
    if (n > 0) px[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) pixel_q.push_back(px[i]);
  endfunction

  // Result checking
  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (pixel_q.size() == 0) begin
        $error("pixel transfer with nothing expected: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        n_fail++;
      end else begin
        want = pixel_q.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("row_last_pixel", want.row_last_pixel, got.row_last_pixel);
        check_field("run_last", want.run_last, got.run_last);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // One pair per transfer; valid stays high on return so back-to-back pairs need no gap
  task automatic send_pair(input in_item_t pair);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= pair;
    do @(posedge clk); while (!in_if.ready);
    predict_pair(pair);
  endtask

  function automatic in_item_t make_pair(logic [7:0] ye, logic [7:0] yo, logic [7:0] cb,
                                         logic [7:0] cr, logic ends_row);
    in_item_t pair;
    pair.luma_even   = ye;
    pair.luma_odd    = yo;
    pair.chroma_blue = cb;
    pair.chroma_red  = cr;
    pair.row_end     = ends_row;
    return pair;
  endfunction

  // sample value biased towards the extremes
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Rows of random length, last pair of each flagged as row end
  task automatic send_rows(input int n_pairs, input int max_len);
    int sent, len;
    sent = 0;
    while (sent < n_pairs) begin
      len = $urandom_range(1, max_len);
      if (len > n_pairs - sent) len = n_pairs - sent;
      for (int i = 0; i < len; i++)
        send_pair(make_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                            i == len - 1));
      sent += len;
    end
  endtask

  // Drop valid, wait for every expected pixel, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    coef[idx] = val;
  endtask

  task automatic write_coefs(input logic [COEF_W-1:0] cr_red, input logic [COEF_W-1:0] cr_green,
                             input logic [COEF_W-1:0] cb_green, input logic [COEF_W-1:0] cb_blue);
    settle();
    write_reg(REG_CR_TO_RED, cr_red);
    write_reg(REG_CR_TO_GREEN, cr_green);
    write_reg(REG_CB_TO_GREEN, cb_green);
    write_reg(REG_CB_TO_BLUE, cb_blue);
    cfg_we <= 1'b0;
  endtask

  // Reset coefficients: lone row-end pairs, short rows, saturation at both ends
  task automatic test_directed();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_pair(make_pair(8'd0, 8'd255, 8'd0, 8'd255, 1'b1));
    send_pair(make_pair(8'd255, 8'd0, 8'd255, 8'd0, 1'b1));
    send_pair(make_pair(8'd0, 8'd0, 8'd128, 8'd128, 1'b0));
    send_pair(make_pair(8'd255, 8'd255, 8'd128, 8'd128, 1'b0));
    send_pair(make_pair(8'd128, 8'd128, 8'd0, 8'd255, 1'b1));
    send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    send_pair(make_pair(8'd0, 8'd255, 8'd255, 8'd0, 1'b0));
    send_pair(make_pair(8'd255, 8'd0, 8'd0, 8'd255, 1'b1));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_pair(make_pair(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0));
    send_pair(make_pair(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1));
    // left held across the next coefficient write
    send_pair(make_pair(8'd16, 8'd235, 8'd16, 8'd240, 1'b0));
  endtask

  // Coefficient extremes and random settings, with idling on both sides
  task automatic test_coef_settings();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_coefs('0, '0, '0, '0);
    send_rows(20, 6);
    write_coefs('1, '1, '1, '1);
    send_rows(20, 6);
    write_coefs('1, '0, '1, '0);
    send_rows(20, 6);
    write_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
    send_rows(20, 6);
  endtask

  // Long receiver hold-off while pairs keep coming, so the input stalls
  task automatic test_output_stall();
    write_coefs(10'd351, 10'd179, 10'd86, 10'd443);
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    long_hold_req = 1'b1;
    send_rows(16, 4);
  endtask

  task automatic test_random_rows();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_rows(85, 10);
    write_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
    send_rows(85, 10);
  endtask

  // Full rate, no idling on either side
  task automatic test_steady_tail();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_rows(40, 8);
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_CR_TO_RED;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    long_hold_req = 1'b0;
    coef[REG_CR_TO_RED]   = 10'd351;
    coef[REG_CR_TO_GREEN] = 10'd179;
    coef[REG_CB_TO_GREEN] = 10'd86;
    coef[REG_CB_TO_BLUE]  = 10'd443;
    held_valid     = 1'b0;
    held_luma_even = '0;
    held_luma_odd  = '0;
    held_cb        = '0;
    held_cr        = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_coef_settings();
    test_output_stall();
    test_random_rows();
    test_steady_tail();
    settle();

    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: ycbcr422_upsample_to_rgb.f
+incdir+src
src/ycu_pkg.sv
src/ycu_stream_if.sv
src/ycbcr422_upsample_to_rgb.sv
tb/ycbcr422_upsample_to_rgb_tb.sv
